// ----- src/utz_pkg.sv -----
package utz_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // register indexes, taken from paddr[2]
    localparam logic REG_ZONE_HOURS = 1'b0;
    localparam logic REG_EAST       = 1'b1;

    localparam logic [3:0] ZONE_HOURS_RST = 4'd8;
    localparam logic       EAST_RST       = 1'b1;
    localparam logic [3:0] ZONE_HOURS_MAX = 4'd12;

    localparam logic [5:0] HOURS_PER_DAY  = 6'd24;
    localparam logic [6:0] YEARS_PER_CENT = 7'd100;
    localparam logic [6:0] LAST_YEAR      = 7'd99;
    localparam logic [3:0] JANUARY        = 4'd1;
    localparam logic [3:0] FEBRUARY       = 4'd2;
    localparam logic [3:0] DECEMBER       = 4'd12;
    localparam logic [4:0] FIRST_DAY      = 5'd1;
    localparam logic [4:0] DAYS_LONG      = 5'd31;
    localparam logic [4:0] DAYS_SHORT     = 5'd30;
    localparam logic [4:0] DAYS_FEB       = 5'd28;
    localparam logic [4:0] DAYS_FEB_LEAP  = 5'd29;

    typedef struct packed {
        logic [6:0] utc_year;
        logic [3:0] utc_month;
        logic [4:0] utc_day;
        logic [4:0] utc_hour;
        logic [5:0] utc_minute;
        logic [5:0] utc_second;
    } t_utc_word;

    typedef struct packed {
        logic [6:0] local_year;
        logic [3:0] local_month;
        logic [4:0] local_day;
        logic [4:0] local_hour;
        logic [5:0] local_minute;
        logic [5:0] local_second;
    } t_local_word;

    typedef struct packed {
        logic [3:0] zone_hours;
        logic       east_of_greenwich;
    } t_zone_cfg;

    // Years 2000..2099: divisible by four is leap (2000 is a 400 year)
    function automatic logic [4:0] month_len(input logic [3:0] mm, input logic [6:0] yy);
        logic [4:0] len;
        len = DAYS_LONG;
        case (mm) inside
            FEBRUARY:                 len = (yy[1:0] == 2'b00) ? DAYS_FEB_LEAP : DAYS_FEB;
            4'd4, 4'd6, 4'd9, 4'd11:  len = DAYS_SHORT;
            default:                  len = DAYS_LONG;
        endcase
        return len;
    endfunction

endpackage

// ----- src/utz_stream_if.sv -----
interface utz_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/utz_calc.sv -----
module utz_calc (
    input  utz_pkg::t_utc_word   i_utc,
    input  utz_pkg::t_zone_cfg   i_cfg,
    output utz_pkg::t_local_word o_local
);
    import utz_pkg::*;

    logic [6:0] yy;
    logic [3:0] mm;
    logic [4:0] dd;
    logic [5:0] hh_ext;
    logic [5:0] g_ext;
    logic [5:0] sum_e;
    logic [5:0] sum_w;
    logic       shift_on;
    logic       month_ok;
    logic [3:0] mm_prev;

    assign yy       = (i_utc.utc_year >= YEARS_PER_CENT) ? i_utc.utc_year - YEARS_PER_CENT
                                                         : i_utc.utc_year;
    assign mm       = i_utc.utc_month;
    assign dd       = i_utc.utc_day;
    assign hh_ext   = {1'b0, i_utc.utc_hour};
    assign g_ext    = {2'b00, i_cfg.zone_hours};
    assign sum_e    = hh_ext + g_ext;
    assign sum_w    = hh_ext + HOURS_PER_DAY - g_ext;
    assign shift_on = (i_cfg.zone_hours != 4'd0) && (i_cfg.zone_hours <= ZONE_HOURS_MAX);
    assign month_ok = (mm >= JANUARY) && (mm <= DECEMBER);
    assign mm_prev  = mm - 4'd1;

    always_comb begin
        o_local.local_year   = yy;
        o_local.local_month  = mm;
        o_local.local_day    = dd;
        o_local.local_hour   = i_utc.utc_hour;
        o_local.local_minute = i_utc.utc_minute;
        o_local.local_second = i_utc.utc_second;
        if (shift_on) begin
            if (i_cfg.east_of_greenwich) begin
                if (sum_e < HOURS_PER_DAY) begin
                    o_local.local_hour = sum_e[4:0];
                end else begin
                    o_local.local_hour = 5'(sum_e - HOURS_PER_DAY);
                    if (month_ok) begin
                        if (dd < month_len(mm, yy)) begin
                            o_local.local_day = dd + 5'd1;
                        end else begin
                            o_local.local_day = FIRST_DAY;
                            if (mm == DECEMBER) begin
                                o_local.local_month = JANUARY;
                                o_local.local_year  = (yy == LAST_YEAR) ? 7'd0 : yy + 7'd1;
                            end else begin
                                o_local.local_month = mm + 4'd1;
                            end
                        end
                    end
                end
            end else begin
                if (hh_ext >= g_ext) begin
                    o_local.local_hour = 5'(hh_ext - g_ext);
                end else begin
                    o_local.local_hour = sum_w[4:0];
                    if (month_ok) begin
                        if (dd > FIRST_DAY) begin
                            o_local.local_day = dd - 5'd1;
                        end else if (mm == JANUARY) begin
                            o_local.local_month = DECEMBER;
                            o_local.local_day   = DAYS_LONG;
                            o_local.local_year  = (yy == 7'd0) ? LAST_YEAR : yy - 7'd1;
                        end else begin
                            o_local.local_month = mm_prev;
                            o_local.local_day   = month_len(mm_prev, yy);
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- src/utc_to_zone_date_time_unit.sv -----
// An accepted input word is held in the input register, then in the result register, and leaves on o_local.
// Throughput: one word per cycle; input register and result register form a
// two-stage pipeline, so a stalled result holds the input off only once the
// input register also holds a word.
// Reset (i_rst_n low, synchronous): both stages empty, zone_hours = 8,
// east_of_greenwich = 1.
module utc_to_zone_date_time_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    utz_stream_if.sink                          i_utc,
    utz_stream_if.source                        o_local,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [utz_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [utz_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [utz_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import utz_pkg::*;

    t_zone_cfg   r_cfg;
    t_utc_word   r_in;
    logic        r_in_vld;
    t_local_word r_out;
    logic        r_out_vld;
    t_local_word n_out;
    logic        w_out_free;
    logic        w_adv;
    logic        w_in_take;
    logic        w_wr;

    // config registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zone_hours        <= ZONE_HOURS_RST;
            r_cfg.east_of_greenwich <= EAST_RST;
        end else if (w_wr) begin
            case (paddr[2])
                REG_ZONE_HOURS: r_cfg.zone_hours        <= pwdata[3:0];
                REG_EAST:       r_cfg.east_of_greenwich <= pwdata[0];
                default:        r_cfg                   <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ZONE_HOURS: prdata = {28'd0, r_cfg.zone_hours};
            REG_EAST:       prdata = {31'd0, r_cfg.east_of_greenwich};
            default:        prdata = '0;
        endcase
    end

    // pipeline control
    assign w_out_free  = !r_out_vld || o_local.ready;
    assign w_adv       = r_in_vld && w_out_free;
    assign i_utc.ready = !r_in_vld || w_out_free;
    assign w_in_take   = i_utc.valid && i_utc.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_local.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_utc.data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    utz_calc u_calc (
        .i_utc   (r_in),
        .i_cfg   (r_cfg),
        .o_local (n_out)
    );

    assign o_local.valid = r_out_vld;
    assign o_local.data  = r_out;

`ifndef ASSERT_OFF
    a_take_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_in_vld)
        else $error("accepted word not held in input stage");

    a_adv_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_vld)
        else $error("advanced word missing from result stage");

    a_minute_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_out.local_minute == $past(r_in.utc_minute))
                  && (r_out.local_second == $past(r_in.utc_second)))
        else $error("minute or second altered");

    a_hour_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in.utc_hour < 5'd24)) |=> (r_out.local_hour < 5'd24))
        else $error("local hour out of range");

    a_zone_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && (paddr[2] == REG_ZONE_HOURS)) |=> (r_cfg.zone_hours == $past(pwdata[3:0])))
        else $error("zone_hours write lost");
`endif

endmodule

// ----- sim/tb_utc_to_zone_date_time_unit.sv -----
module tb_utc_to_zone_date_time_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import utz_pkg::*;

    localparam logic [2:0] ADDR_ZONE_HOURS = {utz_pkg::REG_ZONE_HOURS, 2'b00};
    localparam logic [2:0] ADDR_EAST       = {utz_pkg::REG_EAST, 2'b00};
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned LONG_HOLD      = 120;
    localparam int unsigned HOLD_AFTER     = 300;
    localparam int unsigned PRINT_CAP      = 50;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    utz_stream_if #(.T(t_utc_word))   utc_if ();
    utz_stream_if #(.T(t_local_word)) local_if ();

    utc_to_zone_date_time_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_utc   (utc_if),
        .o_local (local_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the zone registers
    logic [3:0]  zone_g    = utz_pkg::ZONE_HOURS_RST;
    logic        zone_east = utz_pkg::EAST_RST;

    t_utc_word   utc_pending[$];
    t_local_word local_expected[$];

    int unsigned n_errors    = 0;
    int unsigned n_checked   = 0;
    int unsigned cycles      = 0;
    int unsigned words_taken = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    bit          long_held   = 1'b0;
    bit          calm        = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("utc_to_zone_date_time_unit test failed");
        $finish;
    end

    function automatic bit is_leap(input int unsigned yy);
        int unsigned full;
        full = 2000 + yy;
        return (full % 4 == 0) && ((full % 400 == 0) || (full % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned mm, input int unsigned yy);
        if (mm == utz_pkg::FEBRUARY) return is_leap(yy) ? 29 : 28;
        if (mm == 4 || mm == 6 || mm == 9 || mm == 11) return 30;
        return 31;
    endfunction

    function automatic t_local_word to_local_time(input t_utc_word u, input logic [3:0] g,
                                                  input logic east);
        int unsigned yy;
        int unsigned mm;
        int unsigned dd;
        int unsigned hh;
        bit          month_ok;
        t_local_word r;
        yy = u.utc_year % 100;
        mm = u.utc_month;
        dd = u.utc_day;
        hh = u.utc_hour;
        month_ok = (mm >= 1) && (mm <= 12);
        if (g != 0 && g <= utz_pkg::ZONE_HOURS_MAX) begin
            if (east) begin
                if (hh + g < 24) begin
                    hh = hh + g;
                end else begin
                    hh = hh + g - 24;
                    if (month_ok) begin
                        if (dd < days_in_month(mm, yy)) begin
                            dd++;
                        end else begin
                            dd = 1;
                            if (mm == utz_pkg::DECEMBER) begin
                                mm = utz_pkg::JANUARY;
                                yy = (yy + 1) % 100;
                            end else begin
                                mm++;
                            end
                        end
                    end
                end
            end else begin
                if (hh >= g) begin
                    hh = hh - g;
                end else begin
                    hh = hh + 24 - g;
                    if (month_ok) begin
                        if (dd > 1) begin
                            dd--;
                        end else if (mm == utz_pkg::JANUARY) begin
                            mm = utz_pkg::DECEMBER;
                            dd = 31;
                            yy = (yy + 99) % 100;
                        end else begin
                            // a leap March 1st lands on February 29th here
                            mm--;
                            dd = days_in_month(mm, yy);
                        end
                    end
                end
            end
        end
        r.local_year   = yy[6:0];
        r.local_month  = mm[3:0];
        r.local_day    = dd[4:0];
        r.local_hour   = hh[4:0];
        r.local_minute = u.utc_minute;
        r.local_second = u.utc_second;
        return r;
    endfunction

    function automatic t_utc_word make_utc(input int unsigned y, input int unsigned m,
                                           input int unsigned d, input int unsigned h,
                                           input int unsigned mi, input int unsigned s);
        t_utc_word u;
        u.utc_year   = y[6:0];
        u.utc_month  = m[3:0];
        u.utc_day    = d[4:0];
        u.utc_hour   = h[4:0];
        u.utc_minute = mi[5:0];
        u.utc_second = s[5:0];
        return u;
    endfunction

    // mostly real timestamps near day and month edges, some raw noise
    function automatic t_utc_word random_utc();
        int unsigned yy;
        int unsigned mm;
        int unsigned dd;
        int unsigned hh;
        int unsigned len;
        int unsigned pick;
        if ($urandom_range(0, 99) < 15) begin
            return make_utc($urandom_range(0, 127), $urandom_range(0, 15), $urandom_range(0, 31),
                            $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
        end
        pick = $urandom_range(0, 9);
        yy = (pick == 0) ? 99 : (pick == 1) ? 0 : (pick < 4) ? 4 * $urandom_range(0, 24)
                                                              : $urandom_range(0, 99);
        mm = $urandom_range(1, 12);
        len = days_in_month(mm, yy);
        pick = $urandom_range(0, 9);
        dd = (pick < 2) ? 1 : (pick < 4) ? len : (pick == 4) ? len - 1 : $urandom_range(1, len);
        hh = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 23)
           : ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(20, 23);
        return make_utc(yy, mm, dd, hh, $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    task automatic flag_mismatch(input string msg);
        if (n_errors < PRINT_CAP) $display("MISMATCH: %s", msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got !== want) begin
            flag_mismatch($sformatf("word %0d %s: got %0d, expected %0d",
                                    n_checked, name, got, want));
        end
    endtask

    // called at a rising edge; the register takes the value at the access edge
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ZONE_HOURS) zone_g = value[3:0];
        else zone_east = value[0];
        @(posedge i_clk);
    endtask

    task automatic set_zone(input int unsigned g, input bit east);
        apb_write(ADDR_ZONE_HOURS, {28'($urandom), g[3:0]});
        apb_write(ADDR_EAST, {31'($urandom), east});
    endtask

    task automatic wait_drained();
        while (utc_pending.size() != 0 || utc_if.valid || local_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            utc_if.valid <= 1'b0;
            gap_left     <= 0;
        end else if (!utc_if.valid || utc_if.ready) begin
            if (gap_left != 0) begin
                gap_left     <= gap_left - 1;
                utc_if.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                gap_left     <= $urandom_range(0, 13);
                utc_if.valid <= 1'b0;
            end else if (utc_pending.size() != 0) begin
                utc_if.data  <= utc_pending.pop_front();
                utc_if.valid <= 1'b1;
            end else begin
                utc_if.valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off so that the pipeline backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            local_if.ready <= 1'b0;
            stall_left     <= 0;
        end else begin
            if (local_if.valid && local_if.ready) words_taken <= words_taken + 1;
            if (!long_held && words_taken >= HOLD_AFTER && utc_pending.size() > 4) begin
                long_held      <= 1'b1;
                stall_left     <= LONG_HOLD;
                local_if.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left     <= stall_left - 1;
                local_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left     <= $urandom_range(0, 13);
                local_if.ready <= 1'b0;
            end else begin
                local_if.ready <= 1'b1;
            end
        end
    end

    // checker: compare the outgoing word first, then log the incoming one
    always @(posedge i_clk) begin
        t_local_word want;
        if (i_rst_n) begin
            if (local_if.valid && local_if.ready) begin
                if (local_expected.size() == 0) begin
                    flag_mismatch($sformatf("word %0d arrived with nothing expected", n_checked));
                end else begin
                    want = local_expected.pop_front();
                    check_field("year",   local_if.data.local_year,   want.local_year);
                    check_field("month",  local_if.data.local_month,  want.local_month);
                    check_field("day",    local_if.data.local_day,    want.local_day);
                    check_field("hour",   local_if.data.local_hour,   want.local_hour);
                    check_field("minute", local_if.data.local_minute, want.local_minute);
                    check_field("second", local_if.data.local_second, want.local_second);
                end
                n_checked++;
            end
            if (utc_if.valid && utc_if.ready)
                local_expected.push_back(to_local_time(utc_if.data, zone_g, zone_east));
        end
    end

    initial begin
        int unsigned phase_g[8]    = '{1, 12, 0, 5, 13, 15, 12, 11};
        bit          phase_east[8] = '{1, 0, 1, 0, 1, 0, 1, 0};
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset zone: eight hours east
        utc_pending.push_back(make_utc(99, 12, 31, 20, 59, 59));   // year wrap
        utc_pending.push_back(make_utc(4, 2, 28, 23, 0, 1));       // leap February
        utc_pending.push_back(make_utc(1, 2, 28, 16, 30, 30));
        utc_pending.push_back(make_utc(0, 2, 29, 16, 1, 2));       // 2000 is leap
        utc_pending.push_back(make_utc(10, 4, 31, 22, 5, 5));      // day past month end
        utc_pending.push_back(make_utc(10, 0, 15, 22, 7, 7));      // month out of range
        utc_pending.push_back(make_utc(10, 15, 31, 30, 8, 8));
        utc_pending.push_back(make_utc(127, 6, 10, 31, 63, 63));   // year above 99
        utc_pending.push_back(make_utc(0, 1, 1, 0, 0, 0));
        wait_drained();

        set_zone(12, 1'b0);
        utc_pending.push_back(make_utc(4, 3, 1, 5, 10, 10));       // leap March 1st west
        utc_pending.push_back(make_utc(3, 3, 1, 5, 11, 11));
        utc_pending.push_back(make_utc(0, 1, 1, 0, 0, 0));         // back into year 99
        utc_pending.push_back(make_utc(10, 5, 0, 3, 12, 12));      // day zero
        utc_pending.push_back(make_utc(10, 13, 1, 3, 13, 13));
        utc_pending.push_back(make_utc(10, 7, 31, 12, 14, 14));
        utc_pending.push_back(make_utc(127, 8, 1, 31, 63, 63));
        wait_drained();

        set_zone(0, 1'b0);
        utc_pending.push_back(make_utc(127, 15, 31, 31, 63, 63));  // zero offset
        wait_drained();
        set_zone(15, 1'b1);
        utc_pending.push_back(make_utc(99, 12, 31, 23, 59, 59));   // offset above twelve
        wait_drained();
        set_zone(13, 1'b0);
        utc_pending.push_back(make_utc(0, 1, 1, 0, 0, 0));
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            set_zone(phase_g[p], phase_east[p]);
            if (p == 7) calm = 1'b1;
            repeat (106) utc_pending.push_back(random_utc());
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (local_expected.size() != 0)
            flag_mismatch($sformatf("%0d words never arrived", local_expected.size()));
        if (n_errors == 0) begin
            $display("utc_to_zone_date_time_unit test passed");
        end else begin
            $display("utc_to_zone_date_time_unit test failed");
        end
        $finish;
    end

endmodule
